// ===== rtl/mcfw_pkg.sv =====
// Package for the masked command field writer.
// Holds the command row table, conversion codes and shared request/response types.
// No dependencies.
package mcfw_pkg;

    localparam int CMD_BYTES  = 128;
    localparam int ROW_COUNT  = 37;
    localparam int SLOT_COUNT = 30;
    localparam int SLOT_W     = 5;

    typedef enum logic [1:0] {
        RULE_ADD     = 2'd0,
        RULE_MUL     = 2'd1,
        RULE_INC_MUL = 2'd2,
        RULE_MODE    = 2'd3
    } rule_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

    localparam logic REQ_SET   = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    localparam logic [7:0] MODE_BYTES [8] = '{
        8'd18, 8'd19, 8'd24, 8'd33, 8'd34, 8'd35, 8'd40, 8'd40
    };

    typedef struct packed {
        logic               known;
        logic [SLOT_W-1:0]  slot;
        logic [6:0]         pos;
        logic [7:0]         mask;
        rule_t              rule;
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        logic [7:0]         factor;
    } row_t;

    // converted set request, handed to the buffer store
    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
        logic [6:0]        pos;
        logic [7:0]        mask;
        logic [7:0]        data;
    } cvt_t;

    typedef struct packed {
        logic       conflict;
        logic [7:0] merged;
        logic       pending;
    } store_rsp_t;

    function automatic row_t mk_row(input int slot, input int pos, input int mask,
                                    input rule_t rule, input int lo, input int hi,
                                    input int factor);
        row_t r;
        r.known  = 1'b1;
        r.slot   = SLOT_W'(slot);
        r.pos    = 7'(pos % CMD_BYTES);
        r.mask   = 8'(mask);
        r.rule   = rule;
        r.lo     = 16'(lo);
        r.hi     = 16'(hi);
        r.factor = 8'(factor);
        return r;
    endfunction

    // only the low byte of the factor matters, the result wraps modulo 256
    function automatic row_t row_lookup(input logic [5:0] idx);
        row_t r;
        r = '0;
        case (idx)
            6'd0:  r = mk_row( 0,  4, 8'h03, RULE_ADD,       0,   1,   1);
            6'd1:  r = mk_row( 1,  5, 8'h30, RULE_INC_MUL,   0,   1,  16);
            6'd2:  r = mk_row( 2,  7, 8'hFF, RULE_INC_MUL,   0,   3,   8);
            6'd3:  r = mk_row( 2,  7, 8'hFF, RULE_ADD,       0,   3,  73);
            6'd4:  r = mk_row( 3, 38, 8'hFF, RULE_ADD,      -5,  65, 128);
            6'd5:  r = mk_row( 4, 39, 8'hFF, RULE_ADD,      -5,  65, 128);
            6'd6:  r = mk_row( 5,  6, 8'hFF, RULE_MODE,      0,   6,   0);
            6'd7:  r = mk_row( 0,  4, 8'hC0, RULE_INC_MUL,   0,   1,  64);
            6'd8:  r = mk_row( 6, 42, 8'hFF, RULE_ADD,      40,  75, 128);
            6'd9:  r = mk_row( 7,  8, 8'h02, RULE_MUL,       0,   1,   2);
            6'd10: r = mk_row( 7,  8, 8'h04, RULE_MUL,       0,   1,   4);
            6'd11: r = mk_row( 0,  4, 8'h30, RULE_INC_MUL,   0,   2,  16);
            6'd12: r = mk_row( 8, 45, 8'hFF, RULE_ADD,      65, 254,   1);
            6'd13: r = mk_row( 9, 84, 8'hFF, RULE_ADD,       1,  15, 128);
            6'd14: r = mk_row(10, 94, 8'hFF, RULE_ADD,       1,  15, 128);
            6'd15: r = mk_row(11, 99, 8'hFF, RULE_ADD,     -15,  15, 128);
            6'd16: r = mk_row(12, 98, 8'hFF, RULE_ADD,       5, 240,   1);
            6'd17: r = mk_row(13, 85, 8'hFF, RULE_ADD,     -20,  35, 128);
            6'd18: r = mk_row(14, 83, 8'hFF, RULE_ADD,       5,  35, 128);
            6'd19: r = mk_row(15, 72, 8'hFF, RULE_ADD,       0, 254,   1);
            6'd20: r = mk_row(16, 71, 8'hFF, RULE_ADD,       0, 254,   1);
            6'd21: r = mk_row(17, 74, 8'hFF, RULE_ADD,       0, 254,   1);
            6'd22: r = mk_row(18, 73, 8'hFF, RULE_ADD,       0, 254,   1);
            6'd23: r = mk_row(19, 97, 8'hFF, RULE_ADD,       0, 254,   1);
            6'd24: r = mk_row(20, 75, 8'hFF, RULE_ADD,      20,  55, 128);
            6'd25: r = mk_row(21, 76, 8'hFF, RULE_ADD,      20,  55, 128);
            6'd26: r = mk_row(22, 77, 8'hFF, RULE_ADD,     -15,  15, 128);
            6'd27: r = mk_row(23, 78, 8'hFF, RULE_ADD,     -15,  15, 128);
            6'd28: r = mk_row(24, 86, 8'hFF, RULE_ADD,       5,  20, 128);
            6'd29: r = mk_row(25, 87, 8'hFF, RULE_ADD,       5,  20, 128);
            6'd30: r = mk_row(26, 88, 8'hFF, RULE_ADD,      15,  30, 128);
            6'd31: r = mk_row(27, 89, 8'hFF, RULE_ADD,      15,  30, 128);
            6'd32: r = mk_row(28, 28, 8'h03, RULE_INC_MUL,   0,   1,   1);
            6'd33: r = mk_row(28, 28, 8'h0C, RULE_INC_MUL,   0,   1,   4);
            6'd34: r = mk_row(29,  9, 8'h03, RULE_INC_MUL,   0,   1,   1);
            6'd35: r = mk_row(29,  9, 8'h0C, RULE_INC_MUL,   0,   1,   4);
            6'd36: r = mk_row( 1,  5, 8'h0C, RULE_INC_MUL,   0,   1,   4);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/mcfw_convert.sv =====
// Row lookup, range check and byte conversion for one set request.
// Depends on mcfw_pkg (row table, rule and status codes).
module mcfw_convert (
    input  logic [5:0]          command_index,
    input  logic signed [15:0]  value,
    output mcfw_pkg::cvt_t      cvt
);

    mcfw_pkg::row_t row;
    logic [7:0]     v8;
    logic [7:0]     mul_a;
    logic [15:0]    prod;
    logic [7:0]     data;

    always_comb
    begin
        row   = mcfw_pkg::row_lookup(command_index);
        v8    = value[7:0];
        mul_a = (row.rule == mcfw_pkg::RULE_INC_MUL) ? v8 + 8'd1 : v8;
        prod  = {8'd0, mul_a} * {8'd0, row.factor};
        case (row.rule)
            mcfw_pkg::RULE_ADD:     data = v8 + row.factor;
            mcfw_pkg::RULE_MUL:     data = prod[7:0];
            mcfw_pkg::RULE_INC_MUL: data = prod[7:0];
            mcfw_pkg::RULE_MODE:    data = mcfw_pkg::MODE_BYTES[value[2:0]];
            default:                data = 8'd0;
        endcase

        cvt.slot = row.slot;
        cvt.pos  = row.pos;
        cvt.mask = row.mask;
        cvt.data = data;
        if (!row.known)
            cvt.status = mcfw_pkg::ST_UNKNOWN;
        else if (value < row.lo || value > row.hi)
            cvt.status = mcfw_pkg::ST_RANGE;
        else
            cvt.status = mcfw_pkg::ST_OK;
    end

endmodule

// ===== rtl/mcfw_store.sv =====
// Command buffer bytes and claim marks for the positions the row table reaches,
// plus the pending flag. Masked read-modify-write with a combinational merge. Depends on mcfw_pkg.
module mcfw_store (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic                 clr_en,
    input  mcfw_pkg::cvt_t       cvt,
    output mcfw_pkg::store_rsp_t rsp
);

    logic [7:0] buf_reg   [mcfw_pkg::SLOT_COUNT];
    logic [7:0] claim_reg [mcfw_pkg::SLOT_COUNT];
    logic       pending_reg;
    logic       pending_next;
    logic [7:0] merged;

    always_comb
    begin
        merged       = (buf_reg[cvt.slot] & ~cvt.mask) | (cvt.data & cvt.mask);
        pending_next = clr_en ? 1'b0 : (wr_en ? 1'b1 : pending_reg);
        rsp.conflict = |(claim_reg[cvt.slot] & cvt.mask);
        rsp.merged   = merged;
        rsp.pending  = pending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mcfw_pkg::SLOT_COUNT; i++)
            begin
                buf_reg[i]   <= 8'd0;
                claim_reg[i] <= 8'd0;
            end
            pending_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (clr_en)
            begin
                for (int i = 0; i < mcfw_pkg::SLOT_COUNT; i++)
                    claim_reg[i] <= 8'd0;
            end
            else if (wr_en)
            begin
                buf_reg[cvt.slot]   <= merged;
                claim_reg[cvt.slot] <= claim_reg[cvt.slot] | cvt.mask;
            end
        end
    end

endmodule

// ===== rtl/masked_command_field_writer_core.sv =====
// Masked command field writer: top level.
// Uses mcfw_pkg, mcfw_convert and mcfw_store.
//
// One request is taken per clock while in_stall is low. The request is held
// in the input register and its result in the result register, from which
// it is presented. The masked read-modify-write of the buffer and claim
// registers lets the next request see the previous one's update at once.
// A set request to a valid row with an in-range value updates the buffer
// byte, its claim marks and the pending flag; a clear request resets claims
// and pending but keeps the buffer. The buffer is all zero after reset.
module masked_command_field_writer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [5:0]  command_index,
    input  logic [15:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        conflict,
    output logic [6:0]  byte_position,
    output logic [7:0]  byte_value,
    output logic        pending
);

    logic        s1_valid_reg, s1_valid_next;
    logic        req_reg;
    logic [5:0]  idx_reg;
    logic [15:0] value_reg;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  status_reg, status_next;
    logic        conflict_reg, conflict_next;
    logic [6:0]  pos_reg, pos_next;
    logic [7:0]  byte_reg, byte_next;
    logic        pending_reg, pending_next;

    logic        advance;
    logic        accept;
    logic        set_ok;

    mcfw_pkg::cvt_t       cvt;
    mcfw_pkg::store_rsp_t rsp;

    mcfw_convert u_convert (
        .command_index (idx_reg),
        .value         ($signed(value_reg)),
        .cvt           (cvt)
    );

    mcfw_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (advance && set_ok),
        .clr_en (advance && req_reg == mcfw_pkg::REQ_CLEAR),
        .cvt    (cvt),
        .rsp    (rsp)
    );

    always_comb
    begin
        advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
        in_stall = s1_valid_reg && !advance;
        accept   = in_valid && !in_stall;
        set_ok   = (req_reg == mcfw_pkg::REQ_SET) && (cvt.status == mcfw_pkg::ST_OK);

        s1_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        out_valid_next = advance || (out_valid_reg && out_stall);

        status_next   = (req_reg == mcfw_pkg::REQ_CLEAR) ? mcfw_pkg::ST_OK : cvt.status;
        conflict_next = set_ok ? rsp.conflict : 1'b0;
        pos_next      = set_ok ? cvt.pos : 7'd0;
        byte_next     = set_ok ? rsp.merged : 8'd0;
        pending_next  = rsp.pending;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg   <= req_type;
            idx_reg   <= command_index;
            value_reg <= value;
        end
        if (advance)
        begin
            status_reg   <= status_next;
            conflict_reg <= conflict_next;
            pos_reg      <= pos_next;
            byte_reg     <= byte_next;
            pending_reg  <= pending_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign conflict      = conflict_reg;
    assign byte_position = pos_reg;
    assign byte_value    = byte_reg;
    assign pending       = pending_reg;

endmodule

// ===== rtl/mcfw_checker.sv =====
// Port-level checks for masked_command_field_writer_core, attached by bind.
// Depends on mcfw_pkg for the status codes.
module mcfw_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] status,
    input logic       conflict,
    input logic [6:0] byte_position,
    input logic [7:0] byte_value,
    input logic       pending
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(byte_value))
        else $error("result changed while stalled");

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != mcfw_pkg::ST_OK
            |-> !conflict && byte_position == 7'd0 && byte_value == 8'd0)
        else $error("rejected request carries write fields");

    a_clear_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == mcfw_pkg::ST_OK && !pending
            |-> !conflict && byte_position == 7'd0 && byte_value == 8'd0)
        else $error("clear result carries write fields");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == mcfw_pkg::ST_OK || status == mcfw_pkg::ST_UNKNOWN
                      || status == mcfw_pkg::ST_RANGE)
        else $error("status code outside its set");

endmodule

bind masked_command_field_writer_core mcfw_checker u_mcfw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .conflict      (conflict),
    .byte_position (byte_position),
    .byte_value    (byte_value),
    .pending       (pending)
);
